/* rtl/core/tapf_pkg.sv */
// ----------------------------------------------------------------------------
// tapf_pkg
// shared constants, codes and control structs of the antipassback filter
// ----------------------------------------------------------------------------
package tapf_pkg;

  // table geometry and reader inputs
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned INPUT_COUNT = 4;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // field widths
  localparam int unsigned TAG_W   = 64;
  localparam int unsigned TICKS_W = 12;
  localparam int unsigned BYTE_W  = 8;

  // time base in 100 ms ticks
  localparam logic [TICKS_W-1:0] TICKS_PER_SECOND = TICKS_W'(10);
  localparam logic [TICKS_W-1:0] SHORT_HOLD_TICKS = TICKS_W'(5);

  // status byte layout
  localparam int unsigned        TAG_CONTROL_POS = 6;
  localparam logic [BYTE_W-1:0]  BOTH_INPUTS     = 8'h03;
  localparam logic [BYTE_W-1:0]  INPUT_MASK      = BYTE_W'((1 << INPUT_COUNT) - 1);

  // item kinds
  localparam logic [1:0] MODE_TAG    = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  // reject reasons
  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_LOCKOUT = 2'd1;
  localparam logic [1:0] REASON_HOLD    = 2'd2;
  localparam logic [1:0] REASON_NOT_TAG = 2'd3;

  // lock modes
  localparam logic [1:0] LOCK_NONE       = 2'd0;
  localparam logic [1:0] LOCK_NO_TIMEOUT = 2'd1;
  localparam logic [1:0] LOCK_TIMEOUT    = 2'd2;
  localparam logic [1:0] LOCK_RELEASE    = 2'd3;

  // configuration register indexes
  localparam logic [7:0] REG_LOCK_MODE    = 8'd0;
  localparam logic [7:0] REG_LOCKOUT_SEC  = 8'd1;
  localparam logic [7:0] REG_ANTIPASS_SEC = 8'd2;
  localparam logic [7:0] REG_RELEASE_MASK = 8'd3;

  // controller commands to the datapath
  typedef struct packed {
    logic load;    // capture a new request
    logic scan;    // visit one table entry
    logic finish;  // commit state and load the result register
  } ctrl_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic need_scan;  // incoming request walks the table
    logic scan_last;  // scan pointer is on the last entry
    logic out_busy;   // result register holds a stalled result
  } dp_stat_t;

endpackage

/* rtl/core/tag_antipassback_filter_core.sv */
// ----------------------------------------------------------------------------
// tag_antipassback_filter_core
// badge read filter with antipassback table, door lockout and input reporting
// ----------------------------------------------------------------------------
// Takes one request at a time: badge reads, 100 ms ticks and reader status
// bytes, and returns exactly one result per request through a result
// register, so a new request can be taken while the last result still waits.
// A badge read with no lockout running, and a tick, walk the 16-entry hold
// table one entry per cycle between capture and commit. A badge read refused
// by a running lockout, a status byte and an unused mode code go straight
// from capture to commit.
// The commit cycle waits while the result register holds a stalled result.
// Configuration writes are always ready and are meant for idle periods.
// ----------------------------------------------------------------------------
module tag_antipassback_filter_core
  import tapf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [TAG_W-1:0]  tag_id_i,
  input  logic [BYTE_W-1:0] reader_status_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              tag_accepted_o,
  output logic [1:0]        reject_reason_o,
  output logic              not_held_o,
  output logic [3:0]        inputs_changed_o,
  output logic [BYTE_W-1:0] input_levels_o,
  output logic              tag_control_changed_o,
  output logic              tag_control_off_o,
  output logic              lockout_active_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // registers are plain flops, a write never has to wait
  assign cfg_ready_o = 1'b1;

  // sequencer: idle, table walk, commit
  tapf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table, counters, config and result register
  tapf_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .mode_i                (mode_i),
    .tag_id_i              (tag_id_i),
    .reader_status_i       (reader_status_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .tag_accepted_o        (tag_accepted_o),
    .reject_reason_o       (reject_reason_o),
    .not_held_o            (not_held_o),
    .inputs_changed_o      (inputs_changed_o),
    .input_levels_o        (input_levels_o),
    .tag_control_changed_o (tag_control_changed_o),
    .tag_control_off_o     (tag_control_off_o),
    .lockout_active_o      (lockout_active_o)
  );

  // a commit never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.finish && out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

  // one request in flight: after an accept the input side stalls
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one is in flight");

  // accepted flag and reason agree
  a_reason_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tag_accepted_o == (reject_reason_o == REASON_NONE)))
    else $error("accept flag and reject reason disagree");

  // only an accepted badge can be flagged as not held
  a_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && not_held_o) |-> tag_accepted_o)
    else $error("not held flag on a refused item");

endmodule

/* rtl/core/tapf_ctrl.sv */
// ----------------------------------------------------------------------------
// tapf_ctrl
// request sequencer: accept, table walk, commit
// ----------------------------------------------------------------------------
module tapf_ctrl
  import tapf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.need_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/tapf_dp.sv */
// ----------------------------------------------------------------------------
// tapf_dp
// datapath: config registers, hold table, lockout counter, result register
// ----------------------------------------------------------------------------
module tapf_dp
  import tapf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_index_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  input  logic [1:0]        mode_i,
  input  logic [TAG_W-1:0]  tag_id_i,
  input  logic [BYTE_W-1:0] reader_status_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              tag_accepted_o,
  output logic [1:0]        reject_reason_o,
  output logic              not_held_o,
  output logic [3:0]        inputs_changed_o,
  output logic [BYTE_W-1:0] input_levels_o,
  output logic              tag_control_changed_o,
  output logic              tag_control_off_o,
  output logic              lockout_active_o
);

  // configuration
  logic [1:0]        lock_mode_q;
  logic [BYTE_W-1:0] lockout_sec_q;
  logic [BYTE_W-1:0] antipass_sec_q;
  logic [BYTE_W-1:0] release_mask_q;

  // persistent state
  logic [TABLE_DEPTH-1:0] held_valid_q;
  logic [TAG_W-1:0]       held_tag_q   [TABLE_DEPTH];
  logic [TICKS_W-1:0]     held_ticks_q [TABLE_DEPTH];
  logic [TICKS_W-1:0]     lockout_q, lockout_d;
  logic [BYTE_W-1:0]      last_status_q, last_status_d;

  // current request
  logic [1:0]        item_mode_q;
  logic [TAG_W-1:0]  item_tag_q;
  logic [BYTE_W-1:0] item_status_q;
  logic [IDX_W-1:0]  scan_idx_q;
  logic              found_q;

  // result register
  logic              out_valid_q;
  logic              res_accepted, res_not_held, res_tc_changed;
  logic [1:0]        res_reason;
  logic [3:0]        res_changed;

  logic              blocked;
  logic              table_full;
  logic [IDX_W-1:0]  free_idx;
  logic              store_tag;
  logic [TICKS_W-1:0] hold_ticks;
  logic [TICKS_W-1:0] lockout_load;
  logic [BYTE_W-1:0] diff;
  logic [BYTE_W-1:0] release_hit;
  logic              mask_onehot;

  assign blocked = ((lock_mode_q == LOCK_TIMEOUT) || (lock_mode_q == LOCK_RELEASE))
                   && (lockout_q != '0);
  assign table_full = &held_valid_q;

  // lowest free entry
  always_comb begin
    free_idx = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (!held_valid_q[k]) begin
        free_idx = IDX_W'(k);
      end
    end
  end

  assign hold_ticks   = (antipass_sec_q != '0)
                        ? TICKS_W'(TICKS_W'(antipass_sec_q) * TICKS_PER_SECOND)
                        : SHORT_HOLD_TICKS;
  assign lockout_load = TICKS_W'(TICKS_W'(lockout_sec_q) * TICKS_PER_SECOND);

  assign diff        = item_status_q ^ last_status_q;
  assign release_hit = diff & INPUT_MASK & release_mask_q;
  assign mask_onehot = (release_mask_q != '0)
                       && ((release_mask_q & (release_mask_q - 8'd1)) == '0);

  assign stat_o.need_scan = ((mode_i == MODE_TAG) && !blocked) || (mode_i == MODE_TICK);
  assign stat_o.scan_last = (scan_idx_q == IDX_W'(TABLE_DEPTH - 1));
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

  // commit and result of one request
  always_comb begin
    lockout_d      = lockout_q;
    last_status_d  = last_status_q;
    res_accepted   = 1'b0;
    res_reason     = REASON_NOT_TAG;
    res_not_held   = 1'b0;
    res_changed    = '0;
    res_tc_changed = 1'b0;
    store_tag      = 1'b0;
    if (cmd_i.finish) begin
      unique case (item_mode_q)
        MODE_TAG: begin
          if (blocked) begin
            res_reason = REASON_LOCKOUT;
          end else if (found_q) begin
            res_reason = REASON_HOLD;
          end else begin
            res_accepted = 1'b1;
            res_reason   = REASON_NONE;
            res_not_held = table_full;
            store_tag    = !table_full;
            if (((lock_mode_q == LOCK_TIMEOUT) || (lock_mode_q == LOCK_RELEASE))
                && (lockout_sec_q != '0)) begin
              lockout_d = lockout_load;
            end
          end
        end
        MODE_TICK: begin
          if (lockout_q != '0) begin
            lockout_d = lockout_q - TICKS_W'(1);
          end
        end
        MODE_STATUS: begin
          if (diff != '0) begin
            res_changed    = diff[3:0] & INPUT_MASK[3:0];
            res_tc_changed = diff[TAG_CONTROL_POS];
            last_status_d  = item_status_q;
            if (lock_mode_q == LOCK_RELEASE) begin
              if (mask_onehot && (release_hit != '0)) begin
                lockout_d = '0;
              end
              if ((release_mask_q == BOTH_INPUTS)
                  && ((item_status_q & BOTH_INPUTS) == '0)) begin
                lockout_d = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_mode_q    <= LOCK_NONE;
      lockout_sec_q  <= '0;
      antipass_sec_q <= '0;
      release_mask_q <= '0;
      held_valid_q   <= '0;
      lockout_q      <= '0;
      last_status_q  <= '0;
      scan_idx_q     <= '0;
      found_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_LOCK_MODE:    lock_mode_q    <= cfg_data_i[1:0];
          REG_LOCKOUT_SEC:  lockout_sec_q  <= cfg_data_i;
          REG_ANTIPASS_SEC: antipass_sec_q <= cfg_data_i;
          REG_RELEASE_MASK: release_mask_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.load) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end
      if (cmd_i.scan) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
        if (item_mode_q == MODE_TAG) begin
          if (held_valid_q[scan_idx_q] && (held_tag_q[scan_idx_q] == item_tag_q)) begin
            found_q <= 1'b1;
          end
        end else if (held_valid_q[scan_idx_q]
                     && (held_ticks_q[scan_idx_q] <= TICKS_W'(1))) begin
          held_valid_q[scan_idx_q] <= 1'b0;
        end
      end
      if (store_tag) begin
        held_valid_q[free_idx] <= 1'b1;
      end
      lockout_q     <= lockout_d;
      last_status_q <= last_status_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_mode_q   <= mode_i;
      item_tag_q    <= tag_id_i;
      item_status_q <= reader_status_i;
    end
    if (cmd_i.scan && (item_mode_q == MODE_TICK)) begin
      held_ticks_q[scan_idx_q] <= held_ticks_q[scan_idx_q] - TICKS_W'(1);
    end
    if (store_tag) begin
      held_tag_q[free_idx]   <= item_tag_q;
      held_ticks_q[free_idx] <= hold_ticks;
    end
    if (cmd_i.finish) begin
      tag_accepted_o        <= res_accepted;
      reject_reason_o       <= res_reason;
      not_held_o            <= res_not_held;
      inputs_changed_o      <= res_changed;
      input_levels_o        <= last_status_d;
      tag_control_changed_o <= res_tc_changed;
      tag_control_off_o     <= last_status_d[TAG_CONTROL_POS];
      lockout_active_o      <= (lockout_d != '0);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
